[rtl/ftba_pkg.sv]
// Shared constants, codes and control types of the frame tag bitmap allocator.
package ftba_pkg;

   // Default sizing handed to the top level
   localparam int DEF_NUM_IDS     = 1024;
   localparam int DEF_WORD_BITS   = 32;
   localparam int DEF_HANDLE_BITS = 64;

   // Fixed field widths of the request and response ports
   localparam int ACTION_BITS       = 2;
   localparam int ID_FIELD_BITS     = 10;
   localparam int HANDLE_FIELD_BITS = 64;
   localparam int STATUS_BITS       = 2;

   // Number of per-word full flags examined in one scan cycle
   localparam int SCAN_CHUNK   = 32;
   localparam int SCAN_CHUNK_W = 5;

   // Request actions
   localparam logic [ACTION_BITS-1:0] ACT_ASSIGN = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FREE   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd2;
   // Spare action code, answered as a miss
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   // Response status codes
   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture request fields
      logic clear;      // clear one bitmap word
      logic scan;       // examine one chunk of full flags
      logic mark;       // claim lowest free ID of the found word
      logic decode;     // split the ID and read bitmap and handle
      logic check;      // finish a free or lookup
      logic resp_full;  // answer with pool full
      logic resp_miss;  // answer with ID not assigned
   } ftba_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic pool_full;
      logic scan_found;
      logic scan_last;
   } ftba_stat_type;

endpackage

[rtl/ftba_ctrl.sv]
// Controller state machine of the frame tag bitmap allocator.
module ftba_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ftba_pkg::ACTION_BITS-1:0]     req_action,
   input  ftba_pkg::ftba_stat_type              stat,
   output ftba_pkg::ftba_cmd_type               cmd,
   output logic                                 busy
);
   import ftba_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_MARK   = 6'b001000,
      S_DECODE = 6'b010000,
      S_CHECK  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Decode state and status into datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (req_action) inside
                  ACT_ASSIGN: begin
                     if (stat.pool_full) begin
                        cmd.resp_full = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_FREE, ACT_LOOKUP: begin
                     state_in = S_DECODE;
                  end
                  default: begin
                     cmd.resp_miss = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (stat.scan_found) begin
               cmd.scan = 1'b1;
               state_in = S_MARK;
            end else if (stat.scan_last) begin
               cmd.resp_full = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_IDLE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state; start with the bitmap clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/ftba_datapath.sv]
// Datapath of the frame tag bitmap allocator: bitmap, full flags, handle store, response.
module ftba_datapath #(
   parameter int NUM_IDS     = ftba_pkg::DEF_NUM_IDS,
   parameter int WORD_BITS   = ftba_pkg::DEF_WORD_BITS,
   parameter int HANDLE_BITS = ftba_pkg::DEF_HANDLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ftba_pkg::ftba_cmd_type                 cmd,
   output ftba_pkg::ftba_stat_type                stat,
   input  logic [ftba_pkg::ACTION_BITS-1:0]       req_action,
   input  logic [ftba_pkg::ID_FIELD_BITS-1:0]     req_frame_id,
   input  logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] req_frame_handle,
   output logic                                   rsp_strobe,
   output logic [ftba_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [ftba_pkg::ID_FIELD_BITS-1:0]     rsp_result_id,
   output logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] rsp_result_handle
);
   import ftba_pkg::*;

   localparam int NUM_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int W_AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int ID_W       = $clog2(NUM_IDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int CNT_W      = $clog2(NUM_IDS + 1);
   localparam int NUM_CHUNKS = (NUM_WORDS + SCAN_CHUNK - 1) / SCAN_CHUNK;
   localparam int PAD_WORDS  = NUM_CHUNKS * SCAN_CHUNK;
   localparam int PAD_W      = $clog2(PAD_WORDS);
   localparam int LAST_BASE  = PAD_WORDS - SCAN_CHUNK;
   localparam int LAST_BITS  = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
   // Reciprocal of the word size for splitting an ID into word and bit
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int PROD_W      = ID_FIELD_BITS + RECIP_SHIFT + 1;
   localparam int DIV_W       = ID_FIELD_BITS + 8;
   localparam int RID_W       = ID_W + 8;

   // Lowest set bit of a bitmap word
   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // Lowest set bit of a chunk of full flags
   function automatic logic [SCAN_CHUNK_W-1:0] lowest_chunk(input logic [SCAN_CHUNK-1:0] v);
      logic [SCAN_CHUNK_W-1:0] idx;
      idx = '0;
      for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SCAN_CHUNK_W'(i);
         end
      end
      return idx;
   endfunction

   // Request capture
   logic [ACTION_BITS-1:0]   act_ff;
   logic [ID_FIELD_BITS-1:0] id_ff;
   logic [HANDLE_BITS-1:0]   handle_ff;
   logic [ID_FIELD_BITS-1:0] quot_ff;
   logic                     in_range_ff;
   logic [PROD_W-1:0]        quot_prod;

   // Allocation state
   logic [W_AW-1:0]      hint_ff, hint_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [W_AW-1:0]      clr_ff;
   logic [NUM_WORDS-1:0] full_ff;
   logic [PAD_W-1:0]     cursor_ff;
   logic [W_AW-1:0]      word_ff;
   logic [BIT_W-1:0]     bit_ff;

   // Memories and their read registers
   logic [WORD_BITS-1:0]   bitmap_mem_ff [NUM_WORDS];
   logic [HANDLE_BITS-1:0] handle_mem_ff [NUM_IDS];
   logic [WORD_BITS-1:0]   bm_rd_ff;
   logic [HANDLE_BITS-1:0] hm_rd_ff;

   // Scan signals
   logic [PAD_WORDS-1:0]    summary_pad;
   logic [PAD_W-1:0]        scan_base;
   logic [SCAN_CHUNK-1:0]   scan_avail;
   logic [PAD_W-1:0]        scan_word;

   // Decode signals
   logic [DIV_W-1:0] div_rem, div_rem_fix;
   logic [DIV_W-1:0] div_quot_fix;

   // Update signals
   logic [WORD_BITS-1:0] word_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]     free_bit;
   logic [WORD_BITS-1:0] set_word, cleared_word;
   logic [RID_W-1:0]     rid_wide;
   logic [ID_W-1:0]      rid;
   logic                 hit;
   logic                 free_hit;

   // Bitmap port selection
   logic                 bm_we, bm_re;
   logic [W_AW-1:0]      bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0] bm_wdata;

   logic [ID_FIELD_BITS-1:0] echo_id;

   // Estimate the word of the requested ID
   assign quot_prod = PROD_W'(req_frame_id) * PROD_W'(RECIP);

   // Pick the chunk of full flags under the cursor, padding words read as full
   always_comb begin
      summary_pad                = '1;
      summary_pad[NUM_WORDS-1:0] = full_ff;
   end
   assign scan_base  = cursor_ff & ~PAD_W'(SCAN_CHUNK - 1);
   assign scan_avail = ~summary_pad[scan_base +: SCAN_CHUNK]
                       & ({SCAN_CHUNK{1'b1}} << cursor_ff[SCAN_CHUNK_W-1:0]);
   assign scan_word  = scan_base + PAD_W'(lowest_chunk(scan_avail));

   // Correct the word estimate by one step
   always_comb begin
      div_rem      = DIV_W'(id_ff) - DIV_W'(quot_ff) * DIV_W'(WORD_BITS);
      div_rem_fix  = div_rem;
      div_quot_fix = DIV_W'(quot_ff);
      if (div_rem >= DIV_W'(WORD_BITS)) begin
         div_rem_fix  = div_rem - DIV_W'(WORD_BITS);
         div_quot_fix = DIV_W'(quot_ff) + DIV_W'(1);
      end
   end

   // Work on the word read from the bitmap
   assign word_mask    = (word_ff == W_AW'(NUM_WORDS - 1)) ? LAST_MASK : '1;
   assign free_bits    = ~bm_rd_ff & word_mask;
   assign free_bit     = lowest_bit(free_bits);
   assign set_word     = bm_rd_ff | (WORD_BITS'(1) << free_bit);
   assign cleared_word = bm_rd_ff & ~(WORD_BITS'(1) << bit_ff);
   assign rid_wide     = RID_W'(word_ff) * RID_W'(WORD_BITS) + RID_W'(free_bit);
   assign rid          = ID_W'(rid_wide);
   assign hit          = in_range_ff && bm_rd_ff[bit_ff];
   assign free_hit     = cmd.check && hit && (act_ff == ACT_FREE);

   // Select the bitmap write and read ports
   always_comb begin
      bm_we    = cmd.clear || cmd.mark || free_hit;
      bm_waddr = cmd.clear ? clr_ff : word_ff;
      bm_wdata = cmd.clear ? '0 : (cmd.mark ? set_word : cleared_word);
      bm_re    = (cmd.scan && stat.scan_found) || cmd.decode;
      bm_raddr = cmd.decode ? W_AW'(div_quot_fix) : W_AW'(scan_word);
   end

   // Bitmap memory
   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem_ff[bm_waddr] <= bm_wdata;
      end
      if (bm_re) begin
         bm_rd_ff <= bitmap_mem_ff[bm_raddr];
      end
   end

   // Handle memory
   always_ff @(posedge clock) begin
      if (cmd.mark) begin
         handle_mem_ff[rid] <= handle_ff;
      end
      if (cmd.decode) begin
         hm_rd_ff <= handle_mem_ff[ID_W'(id_ff)];
      end
   end

   // Hold request fields and working indexes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff      <= req_action;
         id_ff       <= req_frame_id;
         handle_ff   <= HANDLE_BITS'(req_frame_handle);
         quot_ff     <= quot_prod[RECIP_SHIFT +: ID_FIELD_BITS];
         in_range_ff <= (32'(req_frame_id) < NUM_IDS);
         cursor_ff   <= PAD_W'(hint_ff);
      end else if (cmd.scan) begin
         if (stat.scan_found) begin
            word_ff <= W_AW'(scan_word);
         end else begin
            cursor_ff <= scan_base + PAD_W'(SCAN_CHUNK);
         end
      end else if (cmd.decode) begin
         word_ff <= W_AW'(div_quot_fix);
         bit_ff  <= BIT_W'(div_rem_fix);
      end
   end

   // Next hint and count
   always_comb begin
      hint_in  = hint_ff;
      count_in = count_ff;
      if (cmd.mark) begin
         hint_in  = word_ff;
         count_in = count_ff + CNT_W'(1);
      end else if (free_hit) begin
         if (word_ff < hint_ff) begin
            hint_in = word_ff;
         end
         if (count_ff != '0) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // Allocation state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff  <= '0;
         count_ff <= '0;
         clr_ff   <= '0;
         full_ff  <= '0;
      end else begin
         hint_ff  <= hint_in;
         count_ff <= count_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + W_AW'(1);
         end
         if (cmd.mark) begin
            full_ff[word_ff] <= &(set_word | ~word_mask);
         end else if (free_hit) begin
            full_ff[word_ff] <= 1'b0;
         end
      end
   end

   // Response registers
   assign echo_id = cmd.accept ? req_frame_id : id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.resp_full || cmd.resp_miss || cmd.mark || cmd.check;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_full) begin
         rsp_status        <= ST_FULL;
         rsp_result_id     <= echo_id;
         rsp_result_handle <= '0;
      end else if (cmd.resp_miss) begin
         rsp_status        <= ST_MISS;
         rsp_result_id     <= echo_id;
         rsp_result_handle <= '0;
      end else if (cmd.mark) begin
         rsp_status        <= ST_OK;
         rsp_result_id     <= ID_FIELD_BITS'(rid);
         rsp_result_handle <= '0;
      end else if (cmd.check) begin
         rsp_status        <= hit ? ST_OK : ST_MISS;
         rsp_result_id     <= id_ff;
         rsp_result_handle <= (hit && (act_ff == ACT_LOOKUP))
                              ? HANDLE_FIELD_BITS'(hm_rd_ff) : '0;
      end
   end

   // Status to the controller
   assign stat.clear_done = (clr_ff == W_AW'(NUM_WORDS - 1));
   assign stat.pool_full  = (count_ff == CNT_W'(NUM_IDS));
   assign stat.scan_found = |scan_avail;
   assign stat.scan_last  = (scan_base == PAD_W'(LAST_BASE));

endmodule

[rtl/frame_tag_bitmap_allocator_unit.sv]
// Top level of the frame tag bitmap allocator: controller and datapath.
//
// A request is taken when start is high and busy is low; its single response
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high and must
// be captured then, since the receiver cannot hold it off. Busy stays high
// after acceptance for as long as the request works: an assign with free IDs
// holds busy through its scan states, which walk the 32-word chunks of per-word
// full flags from the hint word (a single chunk at the default size), and one
// mark state; a free or a lookup holds busy through a decode state (ID split
// into word and bit, bitmap and handle store read through their registered
// ports) and a check state; an assign on a full pool and an unused action code
// answer at once without raising busy. The response strobes in the first cycle
// with busy low again (the cycle after acceptance for an immediate answer), and
// the next request can be taken in that same cycle. After reset the bitmap
// memory is cleared one word per cycle, all NUM_IDS / WORD_BITS words (rounded
// up), with busy held high.
module frame_tag_bitmap_allocator_unit #(
   parameter int NUM_IDS     = ftba_pkg::DEF_NUM_IDS,
   parameter int WORD_BITS   = ftba_pkg::DEF_WORD_BITS,
   parameter int HANDLE_BITS = ftba_pkg::DEF_HANDLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ftba_pkg::ACTION_BITS-1:0]       req_action,
   input  logic [ftba_pkg::ID_FIELD_BITS-1:0]     req_frame_id,
   input  logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] req_frame_handle,
   output logic                                   rsp_strobe,
   output logic [ftba_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [ftba_pkg::ID_FIELD_BITS-1:0]     rsp_result_id,
   output logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] rsp_result_handle
);
   import ftba_pkg::*;

   ftba_cmd_type  cmd;
   ftba_stat_type stat;

   // Sequence each request
   ftba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Hold the bitmap, flags and handles
   ftba_datapath #(
      .NUM_IDS     (NUM_IDS),
      .WORD_BITS   (WORD_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_frame_id      (req_frame_id),
      .req_frame_handle  (req_frame_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_handle (rsp_result_handle)
   );

endmodule

[rtl/ftba_checker.sv]
// Port-level assertions of the frame tag bitmap allocator and their binding.
module ftba_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic [ftba_pkg::ACTION_BITS-1:0]       req_action,
   input logic [ftba_pkg::ID_FIELD_BITS-1:0]     req_frame_id,
   input logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] req_frame_handle,
   input logic                                   rsp_strobe,
   input logic [ftba_pkg::STATUS_BITS-1:0]       rsp_status,
   input logic [ftba_pkg::ID_FIELD_BITS-1:0]     rsp_result_id,
   input logic [ftba_pkg::HANDLE_FIELD_BITS-1:0] rsp_result_handle
);
   import ftba_pkg::*;

   // No response follows an idle cycle without a request
   assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_strobe)
      else $error("response without a request in work");

   // An unused action answers at once with a miss
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_UNUSED) |=>
         (rsp_strobe && rsp_status == ST_MISS && rsp_result_handle == '0))
      else $error("unused action not answered as a miss");

   // A request that does not succeed carries no handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_result_handle == '0))
      else $error("failed request returned a handle");

   // A free or lookup answers after its decode and check states, echoing its ID
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_FREE || req_action == ACT_LOOKUP)) |=>
         busy ##1 busy ##1
         (rsp_strobe && !busy && rsp_result_id == $past(req_frame_id, 3)))
      else $error("free or lookup response mistimed or wrong ID");

endmodule

bind frame_tag_bitmap_allocator_unit ftba_checker u_ftba_checker (.*);

[tb/frame_tag_bitmap_allocator_checker.sv]
// Shadow allocator and response checker for the frame tag bitmap allocator.
module frame_tag_bitmap_allocator_checker
   import ftba_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [ACTION_BITS-1:0]       req_action,
   input  logic [ID_FIELD_BITS-1:0]     req_frame_id,
   input  logic [HANDLE_FIELD_BITS-1:0] req_frame_handle,
   input  logic                         rsp_strobe,
   input  logic [STATUS_BITS-1:0]       rsp_status,
   input  logic [ID_FIELD_BITS-1:0]     rsp_result_id,
   input  logic [HANDLE_FIELD_BITS-1:0] rsp_result_handle,
   output int                           fail_count,
   output int                           outstanding,
   output int                           checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_IDS = DEF_NUM_IDS;
   localparam int MAP_BITS = DEF_WORD_BITS;
   localparam int MAP_WORDS = (POOL_IDS + MAP_BITS - 1) / MAP_BITS;

   typedef struct packed {
      logic [STATUS_BITS-1:0]       status;
      logic [ID_FIELD_BITS-1:0]     id;
      logic [HANDLE_FIELD_BITS-1:0] handle;
   } tag_response_type;

   // Shadow copy of the allocator state
   logic [MAP_BITS-1:0]          id_map [MAP_WORDS];
   logic [HANDLE_FIELD_BITS-1:0] handle_mem [POOL_IDS];
   int                           hint_word;
   int                           ids_in_use;
   tag_response_type             awaited_responses [$];
   int                           mismatches = 0;

   // Work out the response to one request and advance the shadow state
   function automatic tag_response_type predict_tag_response(
      input logic [ACTION_BITS-1:0]       action,
      input logic [ID_FIELD_BITS-1:0]     id,
      input logic [HANDLE_FIELD_BITS-1:0] handle
   );
      tag_response_type r;
      int               w;
      int               b;
      bit               found;
      r.status = ST_MISS;
      r.id     = id;
      r.handle = '0;
      w        = int'(id) / MAP_BITS;
      b        = int'(id) % MAP_BITS;
      found    = 1'b0;
      case (action)
         ACT_ASSIGN: begin
            r.status = ST_FULL;
            // Scan upward from the hint word for the lowest clear bit
            if (ids_in_use < POOL_IDS) begin
               for (int sw = hint_word; sw < MAP_WORDS && !found; sw++) begin
                  for (int sb = 0; sb < MAP_BITS && !found; sb++) begin
                     if (!id_map[sw][sb] && sw * MAP_BITS + sb < POOL_IDS) begin
                        found           = 1'b1;
                        id_map[sw][sb]  = 1'b1;
                        hint_word       = sw;
                        r.id            = ID_FIELD_BITS'(sw * MAP_BITS + sb);
                        handle_mem[r.id] = handle;
                        ids_in_use++;
                        r.status        = ST_OK;
                     end
                  end
               end
            end
         end
         ACT_FREE: begin
            if (id_map[w][b]) begin
               id_map[w][b] = 1'b0;
               if (w < hint_word) hint_word = w;
               ids_in_use--;
               r.status = ST_OK;
            end
         end
         ACT_LOOKUP: begin
            if (id_map[w][b]) begin
               r.handle = handle_mem[id];
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Predict on each accepted request, compare each strobed response
   always @(posedge clock) begin : watch
      tag_response_type want;
      int               delta;
      if (reset) begin
         foreach (id_map[i]) id_map[i] = '0;
         hint_word  = 0;
         ids_in_use = 0;
         awaited_responses.delete();
         outstanding   <= 0;
         checked_count <= 0;
         fail_count    <= mismatches;
      end else begin
         delta = 0;
         if (start && !busy) begin
            awaited_responses.push_back(
               predict_tag_response(req_action, req_frame_id, req_frame_handle));
            delta++;
         end
         if (rsp_strobe) begin
            if (awaited_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with none awaited: status %0d id %0d handle %h",
                           $realtime, rsp_status, rsp_result_id, rsp_result_handle);
            end else begin
               want = awaited_responses.pop_front();
               delta--;
               checked_count <= checked_count + 1;
               if (rsp_status !== want.status || rsp_result_id !== want.id ||
                   rsp_result_handle !== want.handle) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: status %0d/%0d id %0d/%0d handle %h/%h (exp/act)",
                              $realtime, want.status, rsp_status, want.id, rsp_result_id,
                              want.handle, rsp_result_handle);
               end
            end
         end
         outstanding <= outstanding + delta;
         fail_count  <= mismatches;
      end
   end

endmodule

[tb/frame_tag_bitmap_allocator_unit_tb.sv]
// Testbench top for the frame tag bitmap allocator: stimulus, timeout and verdict.
module frame_tag_bitmap_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ftba_pkg::*;

   localparam int POOL_IDS    = DEF_NUM_IDS;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int FILL_ITEMS  = 256;
   localparam int PHASE_ITEMS = 175;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [ACTION_BITS-1:0]       req_action = ACT_ASSIGN;
   logic [ID_FIELD_BITS-1:0]     req_frame_id = '0;
   logic [HANDLE_FIELD_BITS-1:0] req_frame_handle = '0;
   logic                         rsp_strobe;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic [ID_FIELD_BITS-1:0]     rsp_result_id;
   logic [HANDLE_FIELD_BITS-1:0] rsp_result_handle;

   int fail_count;
   int outstanding;
   int checked_count;
   int cycle_count = 0;
   int idle_pct = 0;
   int held_guess = 0;
   int n_assign = 0;
   int n_free = 0;
   int n_lookup = 0;
   int n_unused = 0;

   frame_tag_bitmap_allocator_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_frame_id      (req_frame_id),
      .req_frame_handle  (req_frame_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_handle (rsp_result_handle)
   );

   frame_tag_bitmap_allocator_checker u_chk (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_frame_id      (req_frame_id),
      .req_frame_handle  (req_frame_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_handle (rsp_result_handle),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .checked_count     (checked_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Idle at random, then hold one request until the block takes it
   task automatic send_request(input logic [ACTION_BITS-1:0]       action,
                               input logic [ID_FIELD_BITS-1:0]     id,
                               input logic [HANDLE_FIELD_BITS-1:0] handle);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= action;
      req_frame_id     <= id;
      req_frame_handle <= handle;
      case (action)
         ACT_ASSIGN: begin
            n_assign++;
            if (held_guess < POOL_IDS) held_guess++;
         end
         ACT_FREE: begin
            n_free++;
            if (held_guess > 0) held_guess--;
         end
         ACT_LOOKUP: n_lookup++;
         default:    n_unused++;
      endcase
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every awaited response has come back
   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One random request, ids biased toward the low, densely used range
   task automatic send_random_request(input bit fill_lean);
      int                           r;
      int                           span;
      logic [ACTION_BITS-1:0]       action;
      logic [ID_FIELD_BITS-1:0]     id;
      logic [HANDLE_FIELD_BITS-1:0] handle;
      r = $urandom_range(0, 99);
      if (r < 3)
         action = ACT_UNUSED;
      else if (r < (fill_lean ? 58 : 28))
         action = ACT_ASSIGN;
      else if (r < (fill_lean ? 80 : 78))
         action = ACT_FREE;
      else
         action = ACT_LOOKUP;
      span = (held_guess + 4 > POOL_IDS - 1) ? POOL_IDS - 1 : held_guess + 4;
      if ($urandom_range(0, 99) < 85)
         id = ID_FIELD_BITS'($urandom_range(0, span));
      else
         id = ID_FIELD_BITS'($urandom_range(0, POOL_IDS - 1));
      case ($urandom_range(0, 19))
         0:       handle = '0;
         1:       handle = '1;
         default: handle = {$urandom, $urandom};
      endcase
      send_request(action, id, handle);
   endtask

   initial begin
      bit fill_lean;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pool misses, extreme handles, reuse of a freed ID
      send_request(ACT_LOOKUP, 10'd0, '1);
      send_request(ACT_FREE, 10'd1023, '1);
      send_request(ACT_UNUSED, 10'd1023, '1);
      send_request(ACT_ASSIGN, 10'd1023, '1);
      send_request(ACT_ASSIGN, 10'd0, '0);
      send_request(ACT_ASSIGN, 10'd512, 64'h8000_0000_0000_0001);
      send_request(ACT_LOOKUP, 10'd0, '0);
      send_request(ACT_LOOKUP, 10'd1, '1);
      send_request(ACT_LOOKUP, 10'd2, '0);
      send_request(ACT_FREE, 10'd1, '0);
      send_request(ACT_FREE, 10'd1, '0);
      send_request(ACT_LOOKUP, 10'd1, '0);
      send_request(ACT_ASSIGN, 10'd0, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(ACT_LOOKUP, 10'd1, '0);
      send_request(ACT_UNUSED, 10'd0, '0);
      send_request(ACT_LOOKUP, 10'd1023, '1);
      send_request(ACT_FREE, 10'd0, '0);
      send_request(ACT_FREE, 10'd2, '0);
      send_request(ACT_FREE, 10'd1, '0);
      send_request(ACT_LOOKUP, 10'd2, '0);
      wait_all_answered();
      held_guess = 0;

      // Fill the low words of the pool so the hint walks across several words
      idle_pct = 22;
      for (int i = 0; i < FILL_ITEMS; i++)
         send_request(ACT_ASSIGN, ID_FIELD_BITS'($urandom), {$urandom, $urandom});
      send_request(ACT_LOOKUP, 10'd255, '0);

      // Random mix in three sender gap regimes
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 71 : 0;
         fill_lean = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) fill_lean = $urandom_range(0, 1);
            if ($urandom_range(0, 99) == 0) wait_all_answered();
            send_random_request(fill_lean);
         end
         wait_all_answered();
      end

      // Drain and let the block settle
      start <= 1'b0;
      repeat (16) @(posedge clock);
      $display("Covered %0d requests: %0d assign, %0d free, %0d lookup, %0d unused action",
               n_assign + n_free + n_lookup + n_unused, n_assign, n_free, n_lookup, n_unused);
      $display("Checked %0d responses over a 256-ID fill and 22/71/0 percent sender gaps",
               checked_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
